// File: design/vertex_3d_transform_assert.svh
// ----------------------------------------------------------------------------
// vertex_3d_transform assertion macros
// Shorthand for clocked implication checks that are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef VERTEX_3D_TRANSFORM_ASSERT_SVH
`define VERTEX_3D_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define VT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/vt_pkg.sv
// ----------------------------------------------------------------------------
// vt_pkg
// Shared codes, widths and the elaboration-time trig table generator.
// ----------------------------------------------------------------------------
package vt_pkg;

  localparam int IN_W       = 16;
  localparam int OUT_W      = 24;
  localparam int PARAM_W    = 16;
  localparam int ANGLE_W    = 10;
  localparam int MODE_W     = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TRIG_Q     = 30;
  localparam int TAB_W      = 31;
  localparam int TAB_DEPTH  = 46;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 24'sh7FFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = 24'sh800000;

  // Transform modes
  localparam logic [MODE_W-1:0] MODE_TRANSLATE = 4'd0;
  localparam logic [MODE_W-1:0] MODE_SCALE     = 4'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_X     = 4'd2;
  localparam logic [MODE_W-1:0] MODE_ROT_Y     = 4'd3;
  localparam logic [MODE_W-1:0] MODE_ROT_Z     = 4'd4;
  localparam logic [MODE_W-1:0] MODE_REFL_XY   = 4'd5;
  localparam logic [MODE_W-1:0] MODE_REFL_YZ   = 4'd6;
  localparam logic [MODE_W-1:0] MODE_REFL_XZ   = 4'd7;
  localparam logic [MODE_W-1:0] MODE_SHEAR_X   = 4'd8;
  localparam logic [MODE_W-1:0] MODE_SHEAR_Y   = 4'd9;
  localparam logic [MODE_W-1:0] MODE_SHEAR_Z   = 4'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PARAM_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE   = 3'd4;

  // Final right shift applied to a lane's sum
  typedef enum logic [1:0] {
    SH_NONE = 2'd0,
    SH_Q88  = 2'd1,
    SH_TRIG = 2'd2
  } shift_t;

  // One degree in Q30 (pi/180 rounded)
  localparam logic [63:0] DEG_Q30 = 64'd18740330;

  localparam logic [63:0] SIN_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210, 64'd272};
  localparam logic [63:0] COS_DIV [8] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                          64'd90, 64'd132, 64'd182, 64'd240};

  // Taylor series for 0..45 degrees in Q30; returns {sin, cos}.
  // Only called to build constant tables.
  function automatic logic [2*TAB_W-1:0] series_q30(input int unsigned deg);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic signed [63:0] sv;
    logic signed [63:0] cv;
    x  = 64'(deg) * DEG_Q30;
    x2 = (x * x) >> TRIG_Q;
    ts = x;
    tc = 64'd1 << TRIG_Q;
    sv = $signed(x);
    cv = $signed(64'd1 << TRIG_Q);
    for (int k = 0; k < 8; k++) begin
      ts = ((ts * x2) >> TRIG_Q) / SIN_DIV[k];
      tc = ((tc * x2) >> TRIG_Q) / COS_DIV[k];
      if ((k & 1) == 0) begin
        sv = sv - $signed(ts);
        cv = cv - $signed(tc);
      end else begin
        sv = sv + $signed(ts);
        cv = cv + $signed(tc);
      end
    end
    return {sv[TAB_W-1:0], cv[TAB_W-1:0]};
  endfunction

endpackage

// File: design/vt_trig.sv
// ----------------------------------------------------------------------------
// vt_trig
// Angle sequencer: reduces the angle, folds it to 0..45 degrees, looks up
// Q30 sine/cosine and rounds them into the held trig values.
// ----------------------------------------------------------------------------
module vt_trig #(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   angle_wr,
  input  logic signed [vt_pkg::ANGLE_W-1:0]      angle,
  output logic                                   busy,
  output logic signed [TRIG_FRAC_BITS+1:0]       cos_value,
  output logic signed [TRIG_FRAC_BITS+1:0]       sin_value
);

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int RSH    = vt_pkg::TRIG_Q - TRIG_FRAC_BITS;
  localparam int TW     = vt_pkg::TAB_W;
  localparam logic [TW-1:0] HALF = TW'(1) << (RSH - 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_FOLD   = 5'b00100,
    ST_READ   = 5'b01000,
    ST_ROUND  = 5'b10000
  } trig_state_t;

  trig_state_t        state;
  logic [10:0]        deg;
  logic [1:0]         quad;
  logic [5:0]         idx;
  logic               swap;
  logic [TW-1:0]      s_mag;
  logic [TW-1:0]      c_mag;

  logic [TW-1:0]      sin_tab [vt_pkg::TAB_DEPTH];
  logic [TW-1:0]      cos_tab [vt_pkg::TAB_DEPTH];

  for (genvar i = 0; i < vt_pkg::TAB_DEPTH; i++) begin : g_tab
    localparam logic [2*TW-1:0] SC = vt_pkg::series_q30(i);
    assign sin_tab[i] = SC[2*TW-1:TW];
    assign cos_tab[i] = SC[TW-1:0];
  end

  // Fold logic for the reduced angle
  logic [8:0]         d;
  logic [1:0]         quad_next;
  logic [6:0]         rem;
  logic [TW-1:0]      rs_full;
  logic [TW-1:0]      rc_full;
  logic signed [TRIG_W-1:0] rs;
  logic signed [TRIG_W-1:0] rc;

  always_comb begin
    d = deg[8:0];
    if (d >= 9'd270) begin
      quad_next = 2'd3;
      rem       = 7'(d - 9'd270);
    end else if (d >= 9'd180) begin
      quad_next = 2'd2;
      rem       = 7'(d - 9'd180);
    end else if (d >= 9'd90) begin
      quad_next = 2'd1;
      rem       = 7'(d - 9'd90);
    end else begin
      quad_next = 2'd0;
      rem       = 7'(d);
    end
    rs_full = (s_mag + HALF) >> RSH;
    rc_full = (c_mag + HALF) >> RSH;
    rs      = TRIG_W'(rs_full[TRIG_FRAC_BITS:0]);
    rc      = TRIG_W'(rc_full[TRIG_FRAC_BITS:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cos_value <= TRIG_W'(1) << TRIG_FRAC_BITS;
      sin_value <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (angle_wr) begin
            // shift into a positive range before reduction
            deg   <= 11'(12'(angle) + 12'sd720);
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (deg >= 11'd360) begin
            deg <= deg - 11'd360;
          end else begin
            state <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          quad  <= quad_next;
          swap  <= (rem > 7'd45);
          idx   <= (rem > 7'd45) ? 6'(7'd90 - rem) : 6'(rem);
          state <= ST_READ;
        end
        ST_READ: begin
          s_mag <= swap ? cos_tab[idx] : sin_tab[idx];
          c_mag <= swap ? sin_tab[idx] : cos_tab[idx];
          state <= ST_ROUND;
        end
        ST_ROUND: begin
          case (quad)
            2'd0: begin
              sin_value <= rs;
              cos_value <= rc;
            end
            2'd1: begin
              sin_value <= rc;
              cos_value <= -rs;
            end
            2'd2: begin
              sin_value <= -rs;
              cos_value <= -rc;
            end
            default: begin
              sin_value <= -rc;
              cos_value <= rs;
            end
          endcase
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: design/vt_lane.sv
// ----------------------------------------------------------------------------
// vt_lane
// One coordinate: a*p + b*q, rounded shift, saturation to 24 bits.
// ----------------------------------------------------------------------------
module vt_lane #(
  parameter int CW             = 16,
  parameter int KW             = 17,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                              clk,
  input  logic signed [CW-1:0]              a,
  input  logic signed [KW-1:0]              p,
  input  logic signed [CW-1:0]              b,
  input  logic signed [KW-1:0]              q,
  input  vt_pkg::shift_t                    sh,
  output logic signed [vt_pkg::OUT_W-1:0]   value,
  output logic                              sat
);

  localparam int PW = CW + KW;
  localparam int SW = PW + 1;
  localparam logic [SW-1:0] HALF_Q88  = SW'(1) << 7;
  localparam logic [SW-1:0] HALF_TRIG = SW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic [SW-1:0] POS_LIM   = SW'(24'h7FFFFF);
  localparam logic [SW-1:0] NEG_LIM   = SW'(1) << (vt_pkg::OUT_W - 1);

  logic signed [CW-1:0] a1;
  logic signed [KW-1:0] p1;
  logic signed [CW-1:0] b1;
  logic signed [KW-1:0] q1;
  vt_pkg::shift_t       sh1;
  logic signed [PW-1:0] pa2;
  logic signed [PW-1:0] pb2;
  vt_pkg::shift_t       sh2;
  logic                 neg3;
  logic [SW-1:0]        mag3;
  vt_pkg::shift_t       sh3;
  logic                 neg4;
  logic [SW-1:0]        mag4;

  logic signed [SW-1:0] sum;
  logic [SW-1:0]        rnd;
  logic                 over_p;
  logic                 over_n;

  always_comb begin
    sum = SW'(pa2) + SW'(pb2);
    case (sh3)
      vt_pkg::SH_Q88:  rnd = (mag3 + HALF_Q88) >> 8;
      vt_pkg::SH_TRIG: rnd = (mag3 + HALF_TRIG) >> TRIG_FRAC_BITS;
      default:         rnd = mag3;
    endcase
    over_p = (mag4 > POS_LIM);
    over_n = (mag4 > NEG_LIM);
  end

  always_ff @(posedge clk) begin
    // operand capture
    a1  <= a;
    p1  <= p;
    b1  <= b;
    q1  <= q;
    sh1 <= sh;
    // products
    pa2 <= a1 * p1;
    pb2 <= b1 * q1;
    sh2 <= sh1;
    // sum, split into sign and magnitude
    neg3 <= sum[SW-1];
    mag3 <= sum[SW-1] ? SW'(-sum) : SW'(sum);
    sh3  <= sh2;
    // round halves away from zero on the magnitude
    neg4 <= neg3;
    mag4 <= rnd;
    // clamp and restore the sign
    if (neg4) begin
      value <= over_n ? vt_pkg::OUT_MIN : -$signed(mag4[vt_pkg::OUT_W-1:0]);
      sat   <= over_n;
    end else begin
      value <= over_p ? vt_pkg::OUT_MAX : $signed(mag4[vt_pkg::OUT_W-1:0]);
      sat   <= over_p;
    end
  end

endmodule

// File: design/vertex_3d_transform.sv
// ----------------------------------------------------------------------------
// vertex_3d_transform: one vertex per cycle unless busy; the lane pipeline
// registers capture, multiply, sum, round and clamp. done pulses one cycle
// per result, no backpressure. Angle write: busy high, cfg_ready low (trig update).
// Sync reset: clears config/valid regs, cos=1.0, sin=0; busy is high in reset.
// ----------------------------------------------------------------------------
module vertex_3d_transform #(
  parameter int COORD_BITS     = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // vertex command
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [vt_pkg::IN_W-1:0]        x_in,
  input  logic signed [vt_pkg::IN_W-1:0]        y_in,
  input  logic signed [vt_pkg::IN_W-1:0]        z_in,
  // result word
  output logic                                  done,
  output logic signed [vt_pkg::OUT_W-1:0]       x_out,
  output logic signed [vt_pkg::OUT_W-1:0]       y_out,
  output logic signed [vt_pkg::OUT_W-1:0]       z_out,
  output logic                                  overflow,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [vt_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vt_pkg::CFG_DATA_W-1:0]         cfg_data
);

`include "vertex_3d_transform_assert.svh"

  localparam int CW      = COORD_BITS;
  localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
  // coefficient width: covers trig values and the Q8.8 parameters
  localparam int KW      = (TRIG_W > vt_pkg::PARAM_W + 1) ? TRIG_W : vt_pkg::PARAM_W + 1;
  localparam int LATENCY = 5;

  // --------------------------------------------------------------------------
  // Configuration registers. Writes are taken out of reset whenever the trig
  // sequencer is idle; unknown indexes complete the handshake and are dropped.
  // The angle is kept only in its cos/sin form inside the trig sequencer.
  // --------------------------------------------------------------------------
  logic [vt_pkg::MODE_W-1:0]          mode;
  logic signed [vt_pkg::PARAM_W-1:0]  param_a;
  logic signed [vt_pkg::PARAM_W-1:0]  param_b;
  logic signed [vt_pkg::PARAM_W-1:0]  param_c;

  logic                               trig_busy;
  logic signed [TRIG_W-1:0]           cos_value;
  logic signed [TRIG_W-1:0]           sin_value;
  logic                               cfg_write;
  logic                               angle_wr;
  logic                               accept;

  assign cfg_ready = !rst && !trig_busy;
  assign cfg_write = cfg_valid && cfg_ready;
  assign angle_wr  = cfg_write && (cfg_index == vt_pkg::REG_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= '0;
      param_a   <= '0;
      param_b   <= '0;
      param_c   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        vt_pkg::REG_MODE:    mode      <= cfg_data[vt_pkg::MODE_W-1:0];
        vt_pkg::REG_PARAM_A: param_a   <= $signed(cfg_data);
        vt_pkg::REG_PARAM_B: param_b   <= $signed(cfg_data);
        vt_pkg::REG_PARAM_C: param_c   <= $signed(cfg_data);
        default: ;  // angle goes to the trig sequencer
      endcase
    end
  end

  // Trig sequencer: recomputes cos/sin after every angle write. The angle is
  // taken straight from the write word so the update starts the same edge.
  vt_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk       (clk),
    .rst       (rst),
    .angle_wr  (angle_wr),
    .angle     ($signed(cfg_data[vt_pkg::ANGLE_W-1:0])),
    .busy      (trig_busy),
    .cos_value (cos_value),
    .sin_value (sin_value)
  );

  // Vertices are refused in reset and while cos/sin are being rebuilt.
  assign busy   = rst || trig_busy;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Input coordinates, taken as signed from their low COORD_BITS bits. A
  // coordinate wider than the port has a clear top bit and reads positive.
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] coord [3];

  if (CW <= vt_pkg::IN_W) begin : g_narrow
    assign coord[0] = $signed(x_in[CW-1:0]);
    assign coord[1] = $signed(y_in[CW-1:0]);
    assign coord[2] = $signed(z_in[CW-1:0]);
  end else begin : g_wide
    assign coord[0] = $signed(CW'($unsigned(x_in)));
    assign coord[1] = $signed(CW'($unsigned(y_in)));
    assign coord[2] = $signed(CW'($unsigned(z_in)));
  end

  // Integer part of a Q8.8 value, truncated toward zero.
  function automatic logic signed [8:0] int_part(input logic signed [15:0] v);
    logic signed [16:0] ext;
    logic [16:0]        m;
    logic [8:0]         ip;
    ext = 17'(v);
    m   = ext[16] ? 17'(-ext) : 17'(ext);
    ip  = m[16:8];
    return ext[16] ? -$signed(ip) : $signed(ip);
  endfunction

  logic signed [8:0]    ip_a;
  logic signed [8:0]    ip_b;
  logic signed [8:0]    ip_c;
  logic signed [KW-1:0] k_one;
  logic signed [KW-1:0] k_neg_one;
  logic signed [KW-1:0] k_q88_one;
  logic signed [KW-1:0] k_cos;
  logic signed [KW-1:0] k_sin;
  logic signed [KW-1:0] k_nsin;
  logic signed [KW-1:0] k_pa;
  logic signed [KW-1:0] k_pb;

  // Per-lane operands: result = (a*p + b*q) shifted right with rounding.
  logic signed [CW-1:0] op_a  [3];
  logic signed [KW-1:0] op_p  [3];
  logic signed [CW-1:0] op_b  [3];
  logic signed [KW-1:0] op_q  [3];
  vt_pkg::shift_t       op_sh [3];

  always_comb begin
    ip_a      = int_part(param_a);
    ip_b      = int_part(param_b);
    ip_c      = int_part(param_c);
    k_one     = KW'(1);
    k_neg_one = -KW'(1);
    k_q88_one = KW'(256);
    k_cos     = KW'(cos_value);
    k_sin     = KW'(sin_value);
    k_nsin    = -KW'(sin_value);
    k_pa      = KW'(param_a);
    k_pb      = KW'(param_b);

    // untouched coordinates pass through as a*1
    for (int i = 0; i < 3; i++) begin
      op_a[i]  = coord[i];
      op_p[i]  = k_one;
      op_b[i]  = '0;
      op_q[i]  = '0;
      op_sh[i] = vt_pkg::SH_NONE;
    end

    case (mode)
      vt_pkg::MODE_TRANSLATE: begin
        // offsets ride on the coefficient side, which holds -128..127
        op_b[0] = CW'(1);
        op_b[1] = CW'(1);
        op_b[2] = CW'(1);
        op_q[0] = KW'(ip_a);
        op_q[1] = KW'(ip_b);
        op_q[2] = KW'(ip_c);
      end
      vt_pkg::MODE_SCALE: begin
        op_p[0] = KW'(ip_a);
        op_p[1] = KW'(ip_b);
        op_p[2] = KW'(ip_c);
      end
      vt_pkg::MODE_ROT_X: begin
        op_p[1] = k_cos;  op_b[1] = coord[2];  op_q[1] = k_sin;
        op_p[2] = k_cos;  op_b[2] = coord[1];  op_q[2] = k_nsin;
        op_sh[1] = vt_pkg::SH_TRIG;
        op_sh[2] = vt_pkg::SH_TRIG;
      end
      vt_pkg::MODE_ROT_Y: begin
        op_p[0] = k_cos;  op_b[0] = coord[2];  op_q[0] = k_sin;
        op_p[2] = k_cos;  op_b[2] = coord[0];  op_q[2] = k_nsin;
        op_sh[0] = vt_pkg::SH_TRIG;
        op_sh[2] = vt_pkg::SH_TRIG;
      end
      vt_pkg::MODE_ROT_Z: begin
        op_p[0] = k_cos;  op_b[0] = coord[1];  op_q[0] = k_nsin;
        op_p[1] = k_cos;  op_b[1] = coord[0];  op_q[1] = k_sin;
        op_sh[0] = vt_pkg::SH_TRIG;
        op_sh[1] = vt_pkg::SH_TRIG;
      end
      vt_pkg::MODE_REFL_XY: op_p[2] = k_neg_one;
      vt_pkg::MODE_REFL_YZ: op_p[0] = k_neg_one;
      vt_pkg::MODE_REFL_XZ: op_p[1] = k_neg_one;
      vt_pkg::MODE_SHEAR_X: begin
        op_p[1] = k_q88_one;  op_b[1] = coord[0];  op_q[1] = k_pa;
        op_p[2] = k_q88_one;  op_b[2] = coord[0];  op_q[2] = k_pb;
        op_sh[1] = vt_pkg::SH_Q88;
        op_sh[2] = vt_pkg::SH_Q88;
      end
      vt_pkg::MODE_SHEAR_Y: begin
        op_p[0] = k_q88_one;  op_b[0] = coord[1];  op_q[0] = k_pa;
        op_p[2] = k_q88_one;  op_b[2] = coord[1];  op_q[2] = k_pb;
        op_sh[0] = vt_pkg::SH_Q88;
        op_sh[2] = vt_pkg::SH_Q88;
      end
      vt_pkg::MODE_SHEAR_Z: begin
        op_p[0] = k_q88_one;  op_b[0] = coord[2];  op_q[0] = k_pa;
        op_p[1] = k_q88_one;  op_b[1] = coord[2];  op_q[1] = k_pb;
        op_sh[0] = vt_pkg::SH_Q88;
        op_sh[1] = vt_pkg::SH_Q88;
      end
      default: ;  // unused modes pass the vertex through
    endcase
  end

  // --------------------------------------------------------------------------
  // Three identical lanes: capture, multiply, sum, round, saturate. Lane data
  // advances every cycle; the valid pipe below marks which stage holds a word.
  // --------------------------------------------------------------------------
  logic signed [vt_pkg::OUT_W-1:0] lane_val [3];
  logic                            lane_sat [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vt_lane #(
      .CW             (CW),
      .KW             (KW),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .a     (op_a[g]),
      .p     (op_p[g]),
      .b     (op_b[g]),
      .q     (op_q[g]),
      .sh    (op_sh[g]),
      .value (lane_val[g]),
      .sat   (lane_sat[g])
    );
  end

  logic [LATENCY-1:0] vpipe;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LATENCY-2:0], accept};
    end
  end

  // Results come straight from the lanes' output registers.
  assign done     = vpipe[LATENCY-1];
  assign x_out    = lane_val[0];
  assign y_out    = lane_val[1];
  assign z_out    = lane_val[2];
  assign overflow = lane_sat[0] || lane_sat[1] || lane_sat[2];

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  logic at_rail;

  assign at_rail = (x_out == vt_pkg::OUT_MAX) || (x_out == vt_pkg::OUT_MIN) ||
                   (y_out == vt_pkg::OUT_MAX) || (y_out == vt_pkg::OUT_MIN) ||
                   (z_out == vt_pkg::OUT_MAX) || (z_out == vt_pkg::OUT_MIN);

  `VT_ASSERT_IMPLY(a_done_has_vertex, clk, rst, done, $past(accept, LATENCY), "stray done")
  `VT_ASSERT_NEXT(a_angle_starts_update, clk, rst, angle_wr, busy && !cfg_ready, "no trig update")
  `VT_ASSERT_IMPLY(a_ovf_at_rail, clk, rst, done && overflow, at_rail, "overflow off rail")
  `VT_ASSERT_IMPLY(a_no_accept_in_update, clk, rst, trig_busy, !accept && !cfg_write, "took word")

endmodule

// File: bench/vertex_3d_transform_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_3d_transform_tb
// Self-checking bench for the vertex transform. A queue-fed driver issues
// vertex words with random gaps. A clocked monitor predicts each accepted word
// from a mirror of the registers and checks every result word, field by field.
// Registers are reprogrammed between batches, only once the block is drained.
// ----------------------------------------------------------------------------
module vertex_3d_transform_tb;
  import vt_pkg::*;

  localparam int TRIG_FRAC    = 14;
  localparam int SETTLE       = 8;       // result latency plus trig update margin
  localparam int LIMIT        = 300000;  // cycles before the run is declared hung
  localparam int RANDOM_ITEMS = 1600;
  localparam longint unsigned ONE_DEG_Q30 = 64'd18740330;

  // Mode codes the block does not define; the vertex must pass through.
  localparam logic [MODE_W-1:0] MODE_SPARE_LO = 4'd11;
  localparam logic [MODE_W-1:0] MODE_SPARE_HI = 4'd15;
  // Register indexes past the last defined one; writes must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    int unsigned            gap;   // idle cycles before this word is offered
  } vertex_cmd_t;

  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic                    ovf;
  } vertex_res_t;

  // --------------------------------------------------------------------------
  // Clock, DUT ports, instance
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   start = 1'b0;
  logic signed [IN_W-1:0] x_in  = '0;
  logic signed [IN_W-1:0] y_in  = '0;
  logic signed [IN_W-1:0] z_in  = '0;
  logic                   busy;

  logic                    done;
  logic signed [OUT_W-1:0] x_out;
  logic signed [OUT_W-1:0] y_out;
  logic signed [OUT_W-1:0] z_out;
  logic                    overflow;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_3d_transform u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .x_in      (x_in),
    .y_in      (y_in),
    .z_in      (z_in),
    .done      (done),
    .x_out     (x_out),
    .y_out     (y_out),
    .z_out     (z_out),
    .overflow  (overflow),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  vertex_cmd_t vertex_backlog[$];   // words waiting for the driver
  vertex_res_t expected_xyz[$];     // predicted results, oldest first

  // Register mirror, updated on every accepted configuration word
  logic [MODE_W-1:0]         mode_m  = '0;
  logic signed [PARAM_W-1:0] pa_m    = '0;
  logic signed [PARAM_W-1:0] pb_m    = '0;
  logic signed [PARAM_W-1:0] pc_m    = '0;
  logic [ANGLE_W-1:0]        angle_m = '0;
  longint                    cos_m   = longint'(1) << TRIG_FRAC;
  longint                    sin_m   = 0;

  logic        vtx_taken   = 1'b0;  // a vertex word was accepted at the last edge
  logic        reg_written = 1'b0;  // a configuration word was accepted at the last edge
  logic        gapless     = 1'b0;  // current batch runs back to back
  int unsigned gap_count   = 0;
  int unsigned sent_count     = 0;
  int unsigned accepted_count = 0;
  int unsigned checked_count  = 0;
  int unsigned setting_count  = 0;
  int unsigned error_count    = 0;
  int unsigned cycle_count    = 0;
  logic [15:0] modes_seen     = '0;
  vertex_cmd_t drive_cmd;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Shift right with rounding to nearest, halves away from zero.
  function automatic longint round_away(input longint v, input int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  // Integer part of a Q8.8 value, truncated toward zero.
  function automatic longint whole_part(input logic signed [PARAM_W-1:0] q88);
    longint v;
    v = q88;
    return (v < 0) ? -((-v) >> 8) : (v >> 8);
  endfunction

  function automatic longint clamp24(input longint v, inout logic ovf);
    if (v > OUT_MAX) begin
      ovf = 1'b1;
      return OUT_MAX;
    end
    if (v < OUT_MIN) begin
      ovf = 1'b1;
      return OUT_MIN;
    end
    return v;
  endfunction

  // Sine and cosine in Q30 for 0..45 degrees, nine Taylor terms each.
  function automatic void taylor_q30(input longint unsigned deg,
                                     output longint s, output longint c);
    longint unsigned ang;
    longint unsigned ang2;
    longint unsigned ts;
    longint unsigned tc;
    ang  = deg * ONE_DEG_Q30;
    ang2 = (ang * ang) >> 30;
    ts   = ang;
    tc   = 64'd1 << 30;
    s    = longint'(ang);
    c    = longint'(tc);
    for (int k = 1; k <= 8; k++) begin
      ts = ((ts * ang2) >> 30) / (2 * k * (2 * k + 1));
      tc = ((tc * ang2) >> 30) / ((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
  endfunction

  // Reduce the angle modulo 360, fold into 0..45 and unfold by quadrant.
  function automatic void derive_trig(input logic [ANGLE_W-1:0] ang,
                                      output longint cos_q, output longint sin_q);
    longint a;
    longint d;
    longint quad;
    longint rem;
    longint s0;
    longint c0;
    longint s;
    longint c;
    a    = longint'($signed(ang));
    d    = (a + 720) % 360;
    quad = d / 90;
    rem  = d % 90;
    if (rem <= 45) begin
      taylor_q30(rem, s0, c0);
    end else begin
      taylor_q30(90 - rem, c0, s0);
    end
    case (quad)
      0: begin
        s = s0;
        c = c0;
      end
      1: begin
        s = c0;
        c = -s0;
      end
      2: begin
        s = -s0;
        c = -c0;
      end
      default: begin
        s = -c0;
        c = s0;
      end
    endcase
    sin_q = round_away(s, 30 - TRIG_FRAC);
    cos_q = round_away(c, 30 - TRIG_FRAC);
  endfunction

  // Row vector times the mode's matrix, then round and saturate each lane.
  function automatic vertex_res_t transform_vertex(input logic signed [IN_W-1:0] xi,
                                                   input logic signed [IN_W-1:0] yi,
                                                   input logic signed [IN_W-1:0] zi);
    longint      x;
    longint      y;
    longint      z;
    longint      rx;
    longint      ry;
    longint      rz;
    longint      pa;
    longint      pb;
    vertex_res_t r;
    logic        ovf;
    x   = xi;
    y   = yi;
    z   = zi;
    pa  = pa_m;
    pb  = pb_m;
    rx  = x;
    ry  = y;
    rz  = z;
    ovf = 1'b0;
    case (mode_m)
      MODE_TRANSLATE: begin
        rx = x + whole_part(pa_m);
        ry = y + whole_part(pb_m);
        rz = z + whole_part(pc_m);
      end
      MODE_SCALE: begin
        rx = x * whole_part(pa_m);
        ry = y * whole_part(pb_m);
        rz = z * whole_part(pc_m);
      end
      MODE_ROT_X: begin
        ry = round_away(y * cos_m + z * sin_m, TRIG_FRAC);
        rz = round_away(z * cos_m - y * sin_m, TRIG_FRAC);
      end
      MODE_ROT_Y: begin
        rx = round_away(x * cos_m + z * sin_m, TRIG_FRAC);
        rz = round_away(z * cos_m - x * sin_m, TRIG_FRAC);
      end
      MODE_ROT_Z: begin
        rx = round_away(x * cos_m - y * sin_m, TRIG_FRAC);
        ry = round_away(x * sin_m + y * cos_m, TRIG_FRAC);
      end
      MODE_REFL_XY: rz = -z;
      MODE_REFL_YZ: rx = -x;
      MODE_REFL_XZ: ry = -y;
      MODE_SHEAR_X: begin
        ry = round_away(y * 256 + x * pa, 8);
        rz = round_away(z * 256 + x * pb, 8);
      end
      MODE_SHEAR_Y: begin
        rx = round_away(x * 256 + y * pa, 8);
        rz = round_away(z * 256 + y * pb, 8);
      end
      MODE_SHEAR_Z: begin
        rx = round_away(x * 256 + z * pa, 8);
        ry = round_away(y * 256 + z * pb, 8);
      end
      default: ;  // spare modes pass the vertex through
    endcase
    r.x   = clamp24(rx, ovf);
    r.y   = clamp24(ry, ovf);
    r.z   = clamp24(rz, ovf);
    r.ovf = ovf;
    return r;
  endfunction

  // Mirror one configuration word; unknown indexes are dropped.
  function automatic void mirror_reg(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_MODE:    mode_m = val[MODE_W-1:0];
      REG_PARAM_A: pa_m   = val;
      REG_PARAM_B: pb_m   = val;
      REG_PARAM_C: pc_m   = val;
      REG_ANGLE: begin
        angle_m = val[ANGLE_W-1:0];
        derive_trig(angle_m, cos_m, sin_m);
      end
      default: ;
    endcase
  endfunction

  task automatic compare_field(input string name, input logic signed [OUT_W-1:0] want,
                               input logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: result %0d %s mismatch, expected %0d, actual %0d",
               $time, checked_count, name, want, got);
      error_count++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge. Check the result word first, then
  // predict any vertex word taken at this edge, then mirror a register write.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    vertex_res_t want;
    if (rst) begin
      vtx_taken   <= 1'b0;
      reg_written <= 1'b0;
      mode_m  = '0;
      pa_m    = '0;
      pb_m    = '0;
      pc_m    = '0;
      angle_m = '0;
      cos_m   = longint'(1) << TRIG_FRAC;
      sin_m   = 0;
    end else begin
      vtx_taken   <= start && !busy;
      reg_written <= cfg_valid && cfg_ready;

      if (done) begin
        if (expected_xyz.size() == 0) begin
          $display("%0t: result word with nothing expected, actual x=%0d y=%0d z=%0d ovf=%0b",
                   $time, x_out, y_out, z_out, overflow);
          error_count++;
        end else begin
          want = expected_xyz.pop_front();
          compare_field("x_out", want.x, x_out);
          compare_field("y_out", want.y, y_out);
          compare_field("z_out", want.z, z_out);
          compare_field("overflow", {{(OUT_W-1){1'b0}}, want.ovf},
                        {{(OUT_W-1){1'b0}}, overflow});
          checked_count++;
        end
      end

      if (start && !busy) begin
        expected_xyz.push_back(transform_vertex(x_in, y_in, z_in));
        modes_seen[mode_m] = 1'b1;
        accepted_count++;
      end

      if (cfg_valid && cfg_ready) begin
        mirror_reg(cfg_index, cfg_data);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: change inputs at the falling edge. Hold a word until it is taken,
  // wait out the next word's gap, then offer it. Idle cycles carry noise.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || vtx_taken) begin
      if (vertex_backlog.size() != 0 && gap_count >= vertex_backlog[0].gap) begin
        drive_cmd = vertex_backlog.pop_front();
        gap_count = 0;
        start <= 1'b1;
        x_in  <= drive_cmd.x;
        y_in  <= drive_cmd.y;
        z_in  <= drive_cmd.z;
      end else begin
        if (vertex_backlog.size() != 0) begin
          gap_count++;
        end
        start <= 1'b0;
        x_in  <= IN_W'($urandom);
        y_in  <= IN_W'($urandom);
        z_in  <= IN_W'($urandom);
      end
    end
  end

  // Hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("%0t: run hung after %0d cycles, %0d results still expected",
               $time, cycle_count, expected_xyz.size());
      $display("vertex_3d_transform verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Issue one configuration word; call at a falling edge. Valid stays high on
  // return so a following write can go back to back.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    int unsigned pause;
    pause = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    if (pause != 0) begin
      cfg_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!reg_written);
  endtask

  // Drop the configuration channel and move to a rising edge, where the
  // driver never touches the backlog.
  task automatic open_batch();
    cfg_valid <= 1'b0;
    @(posedge clk);
    gapless = ($urandom_range(0, 3) == 0);
    setting_count++;
  endtask

  task automatic queue_vertex(input logic signed [IN_W-1:0] x,
                              input logic signed [IN_W-1:0] y,
                              input logic signed [IN_W-1:0] z);
    vertex_cmd_t cmd;
    cmd.x   = x;
    cmd.y   = y;
    cmd.z   = z;
    cmd.gap = (gapless || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 11);
    vertex_backlog.push_back(cmd);
    sent_count++;
  endtask

  // Wait until every word is taken and answered, then let the pipe settle.
  task automatic drain();
    do @(negedge clk); while (accepted_count != sent_count || expected_xyz.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_mode();
    logic [MODE_W-1:0] m;
    if ($urandom_range(0, 7) == 0) begin
      m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    end else begin
      m = MODE_W'($urandom_range(MODE_TRANSLATE, MODE_SHEAR_Z));
    end
    // Garbage above the mode field must be ignored.
    return {(CFG_DATA_W-MODE_W)'($urandom), m};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_q88();
    case ($urandom_range(0, 6))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(0, 2048)) - 16'd1024;  // within +-4.0
      3:       return ($urandom_range(0, 1) != 0) ? 16'h0080 : 16'hFF80;  // +-0.5
      4:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_angle();
    int deg;
    case ($urandom_range(0, 3))
      0:       deg = 45 * int'($urandom_range(0, 16)) - 360;   // octant boundaries
      1:       deg = int'($urandom_range(0, 1023)) - 512;      // whole 10-bit range
      default: deg = int'($urandom_range(0, 720)) - 360;
    endcase
    return {(CFG_DATA_W-ANGLE_W)'($urandom), ANGLE_W'(deg)};
  endfunction

  function automatic logic signed [IN_W-1:0] pick_coord();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          3:       return 16'sh0001;
          default: return 16'shFFFF;
        endcase
      end
      1:       return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned random_base;
    int unsigned batch_len;
    bit          first_random;

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Rotation straight out of reset: cos is 1.0 and sin 0, so z-rotation
    // must pass the vertex through.
    write_reg(REG_MODE, MODE_ROT_Z);
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh8000, 16'sd5);
    queue_vertex(16'sh8000, 16'sh7FFF, -16'sd1);
    drain();

    // Translate with extreme offsets; -0.996 truncates to zero.
    write_reg(REG_MODE, MODE_TRANSLATE);
    write_reg(REG_PARAM_A, 16'h7FFF);
    write_reg(REG_PARAM_B, 16'h8000);
    write_reg(REG_PARAM_C, 16'hFF01);
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh8000, 16'sh0000);
    queue_vertex(16'sh8000, 16'sh7FFF, 16'sh8000);
    drain();

    // Scale by the largest and smallest integer factors; 1.5 truncates to 1.
    write_reg(REG_MODE, MODE_SCALE);
    write_reg(REG_PARAM_C, 16'h0180);
    open_batch();
    queue_vertex(16'sh8000, 16'sh8000, 16'sh7FFF);
    queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    drain();

    // Rotations: 45 degrees, then angles outside +-360 that must wrap.
    write_reg(REG_MODE, MODE_ROT_X);
    write_reg(REG_ANGLE, 16'd45);
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000);
    queue_vertex(16'sh8000, 16'sh8000, 16'sh7FFF);
    drain();

    write_reg(REG_MODE, MODE_ROT_Y);
    write_reg(REG_ANGLE, 16'd511);
    open_batch();
    queue_vertex(16'sh8000, 16'sd1234, 16'sh7FFF);
    drain();

    write_reg(REG_MODE, MODE_ROT_Z);
    write_reg(REG_ANGLE, 16'(-512));
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh8000, 16'sd77);
    drain();

    write_reg(REG_ANGLE, 16'd90);
    open_batch();
    queue_vertex(16'sh8000, 16'sh7FFF, 16'sh0000);
    drain();

    // Reflections; negating the most negative coordinate must not wrap.
    write_reg(REG_MODE, MODE_REFL_XY);
    open_batch();
    queue_vertex(16'sd3, 16'sd4, 16'sh8000);
    drain();

    write_reg(REG_MODE, MODE_REFL_YZ);
    open_batch();
    queue_vertex(16'sh8000, 16'sh7FFF, 16'sh8000);
    drain();

    write_reg(REG_MODE, MODE_REFL_XZ);
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    drain();

    // Shear by +-0.5 so both lanes land exactly on halves of both signs.
    write_reg(REG_MODE, MODE_SHEAR_X);
    write_reg(REG_PARAM_A, 16'h0080);
    write_reg(REG_PARAM_B, 16'hFF80);
    open_batch();
    queue_vertex(16'sd1, 16'sd0, 16'sd0);
    queue_vertex(-16'sd1, 16'sd3, -16'sd3);
    drain();

    write_reg(REG_MODE, MODE_SHEAR_Y);
    write_reg(REG_PARAM_A, 16'h7FFF);
    write_reg(REG_PARAM_B, 16'h8000);
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh8000, 16'sh8000);
    drain();

    write_reg(REG_MODE, MODE_SHEAR_Z);
    write_reg(REG_PARAM_A, 16'h8000);
    write_reg(REG_PARAM_B, 16'h7FFF);
    open_batch();
    queue_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF);
    drain();

    // Spare mode codes pass through; set the upper data bits on the way.
    write_reg(REG_MODE, {(CFG_DATA_W-MODE_W)'('1), MODE_SPARE_LO});
    open_batch();
    queue_vertex(16'sh8000, 16'sh7FFF, 16'sd42);
    drain();

    write_reg(REG_MODE, MODE_SPARE_HI);
    open_batch();
    queue_vertex(16'sh7FFF, 16'sh8000, -16'sd42);
    drain();

    // Writes to undefined indexes must leave every register alone.
    write_reg(REG_MODE, MODE_ROT_Y);
    for (int i = REG_SPARE_LO; i <= REG_SPARE_HI; i++) begin
      write_reg(CFG_IDX_W'(i), 16'hFFFF);
    end
    open_batch();
    queue_vertex(16'sd1000, -16'sd2000, 16'sd3000);
    drain();

    // Random batches: a fresh setting, then a burst of vertices under it.
    random_base  = sent_count;
    first_random = 1'b1;
    while (sent_count - random_base < RANDOM_ITEMS) begin
      write_reg(REG_MODE, pick_mode());
      if (first_random || $urandom_range(0, 1) != 0) write_reg(REG_PARAM_A, pick_q88());
      if (first_random || $urandom_range(0, 1) != 0) write_reg(REG_PARAM_B, pick_q88());
      if (first_random || $urandom_range(0, 1) != 0) write_reg(REG_PARAM_C, pick_q88());
      if (first_random || $urandom_range(0, 1) != 0) write_reg(REG_ANGLE, pick_angle());
      if ($urandom_range(0, 9) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
      end
      first_random = 1'b0;
      open_batch();
      batch_len = $urandom_range(1, 64);
      repeat (batch_len) queue_vertex(pick_coord(), pick_coord(), pick_coord());
      drain();
    end

    $display("Checked %0d transformed vertices under %0d register settings.",
             checked_count, setting_count);
    $display("Mode codes exercised (one bit per code, 15 down to 0): %b", modes_seen);
    if (error_count == 0) begin
      $display("vertex_3d_transform verification clean");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("vertex_3d_transform verification failed");
    end
    $finish;
  end

endmodule
